// ===== rtl/arpc_pkg.sv =====
// Shared types, codes and constants of the ARP cache with aging.
package arpc_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int STAMP_W  = 32;
    localparam int AGE_W    = 31;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [AGE_W-1:0]   MAX_AGE_RESET = 31'd300;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 5'd31;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IP_W-1:0]   ip_addr;
        logic [MAC_W-1:0]  mac_addr;
        logic              is_permanent;
    } arpc_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MAC_W-1:0]    mac_out;
        logic [COUNT_W-1:0]  removed_count;
    } arpc_out_t;

    typedef enum logic [2:0] {
        OP_LOOKUP,
        OP_ADD,
        OP_REMOVE,
        OP_TICK,
        OP_FLUSH,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic             perm;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } back_state_t;

    typedef struct packed {
        logic               valid;
        logic               perm;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

// ===== rtl/arpc_front.sv =====
// Input side: accepts items, decodes the function code and pushes commands.
module arpc_front (
    input  logic                in_valid,
    output logic                in_stall,
    input  arpc_pkg::arpc_in_t  in_item,
    input  arpc_pkg::back_stat_t stat,
    input  logic                q_full,
    output logic                q_push,
    output arpc_pkg::cmd_t      q_data
);
    import arpc_pkg::*;

    op_t op;

    always_comb
    begin
        unique case (in_item.func)
            FUNC_LOOKUP: op = OP_LOOKUP;
            FUNC_ADD:    op = OP_ADD;
            FUNC_REMOVE: op = OP_REMOVE;
            FUNC_TICK:   op = OP_TICK;
            FUNC_FLUSH:  op = OP_FLUSH;
            default:     op = OP_NOP;
        endcase
    end

    // hold off items while the queue is full or the table is cleared after reset
    assign in_stall    = q_full || stat.clearing;
    assign q_push      = in_valid && !in_stall;
    assign q_data.op   = op;
    assign q_data.ip   = in_item.ip_addr;
    assign q_data.mac  = in_item.mac_addr;
    assign q_data.perm = in_item.is_permanent;

endmodule

// ===== rtl/arpc_queue.sv =====
// Short command queue between the front and the back.
module arpc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  arpc_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output arpc_pkg::cmd_t head
);
    import arpc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/arpc_back.sv =====
// Execution side: slot memory, scan sequencer, seconds counter and result register.
module arpc_back #(
    parameter int TABLE_DEPTH = arpc_pkg::DEF_TABLE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  arpc_pkg::cmd_t                  q_head,
    output logic                            q_pop,
    output arpc_pkg::back_stat_t            stat,
    input  logic                            cfg_wr_en,
    input  logic [arpc_pkg::AGE_W-1:0]      cfg_wr_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output arpc_pkg::arpc_out_t             out_item
);
    import arpc_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    entry_t             mem [TABLE_DEPTH];
    entry_t             rd_data_reg;

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               issue_on_reg;
    logic               chk_vld_reg;
    logic [IDX_W-1:0]   chk_idx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   found_idx_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [MAC_W-1:0]   mac_hit_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [AGE_W-1:0]   max_age_reg;
    logic               out_valid_reg;
    arpc_out_t          out_reg;

    logic               chk_match, chk_free, chk_expire, chk_last;
    logic [STAMP_W-1:0] age;
    logic               out_free, fin_fire, scan_op;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    arpc_out_t          result;

    assign age        = now_reg - rd_data_reg.stamp;
    assign chk_match  = chk_vld_reg && rd_data_reg.valid && (rd_data_reg.ip == cmd_reg.ip);
    assign chk_free   = chk_vld_reg && !rd_data_reg.valid;
    assign chk_expire = chk_vld_reg && (cmd_reg.op == OP_FLUSH) && rd_data_reg.valid
                        && !rd_data_reg.perm && (age > {1'b0, max_age_reg});
    assign chk_last   = chk_vld_reg && (chk_idx_reg == LAST_IDX);
    assign out_free   = !out_valid_reg || !out_stall;
    assign scan_op    = (q_head.op != OP_TICK) && (q_head.op != OP_NOP);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = scan_op ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (chk_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop         = 1'b0;
        fin_fire      = 1'b0;
        stat.clearing = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = chk_idx_reg;
        mem_wdata     = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                stat.clearing = 1'b1;
                mem_we        = 1'b1;
                mem_waddr     = idx_reg;
            end
            ST_IDLE:
            begin
                q_pop = q_valid;
            end
            ST_SCAN:
            begin
                // drop expired entries as they stream past
                if (chk_expire)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = chk_idx_reg;
                    mem_wdata       = rd_data_reg;
                    mem_wdata.valid = 1'b0;
                end
            end
            ST_FINISH:
            begin
                fin_fire = out_free;
                if (out_free && (cmd_reg.op == OP_ADD) && (found_reg || free_reg))
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = found_reg ? found_idx_reg : free_idx_reg;
                    mem_wdata.valid = 1'b1;
                    mem_wdata.perm  = cmd_reg.perm;
                    mem_wdata.ip    = cmd_reg.ip;
                    mem_wdata.mac   = cmd_reg.mac;
                    mem_wdata.stamp = now_reg;
                end
                else if (out_free && (cmd_reg.op == OP_REMOVE) && found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = found_idx_reg;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        result = '0;
        case (cmd_reg.op)
            OP_LOOKUP:
            begin
                result.status  = found_reg ? STATUS_OK : STATUS_MISS;
                result.mac_out = found_reg ? mac_hit_reg : '0;
            end
            OP_ADD:    result.status = (found_reg || free_reg) ? STATUS_OK : STATUS_FULL;
            OP_REMOVE: result.status = found_reg ? STATUS_OK : STATUS_MISS;
            OP_FLUSH:  result.removed_count = count_reg;
            default:   result = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            issue_on_reg  <= 1'b0;
            chk_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            count_reg     <= '0;
            now_reg       <= '0;
            max_age_reg   <= MAX_AGE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_vld_reg <= issue_on_reg;
            if (cfg_wr_en)
            begin
                max_age_reg <= cfg_wr_data;
            end
            if (state_reg == ST_CLEAR && idx_reg != LAST_IDX)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (q_pop)
            begin
                idx_reg      <= '0;
                issue_on_reg <= scan_op;
                found_reg    <= 1'b0;
                free_reg     <= 1'b0;
                count_reg    <= '0;
            end
            else if (issue_on_reg)
            begin
                if (idx_reg == LAST_IDX)
                begin
                    issue_on_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (chk_match && !found_reg)
            begin
                found_reg <= 1'b1;
            end
            if (chk_free && !free_reg)
            begin
                free_reg <= 1'b1;
            end
            if (chk_expire && count_reg != COUNT_MAX)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (fin_fire && cmd_reg.op == OP_TICK)
            begin
                now_reg <= now_reg + 1'b1;
            end
            if (fin_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_head;
        end
        chk_idx_reg <= idx_reg;
        if (chk_match && !found_reg)
        begin
            found_idx_reg <= chk_idx_reg;
            mac_hit_reg   <= rd_data_reg.mac;
        end
        if (chk_free && !free_reg)
        begin
            free_idx_reg <= chk_idx_reg;
        end
        if (fin_fire)
        begin
            out_reg <= result;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== rtl/arp_cache_with_aging_unit.sv =====
// Top level of the ARP cache with aging: front, command queue and back.
// Lookup, add, remove and flush scan every slot of the table before their result; tick and
// unused codes skip the scan. One item runs in the back at a time, so the back takes no new
// item before the result of the last one is registered.
// A two-entry queue takes items while the back works or a result waits.
// After reset a clearing pass over every slot holds in_stall high.
module arp_cache_with_aging_unit #(
    parameter int TABLE_DEPTH = arpc_pkg::DEF_TABLE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  arpc_pkg::arpc_in_t         in_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output arpc_pkg::arpc_out_t        out_item,
    input  logic                       cfg_wr_en,
    input  logic [arpc_pkg::AGE_W-1:0] cfg_wr_data
);
    import arpc_pkg::*;

    back_stat_t stat;
    logic       q_full, q_push, q_pop, q_valid;
    cmd_t       q_data, q_head;

    arpc_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .stat     (stat),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    arpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    arpc_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

endmodule

// ===== rtl/arpc_checker.sv =====
// Port-level checker for the ARP cache with aging, bound to the top level.
module arpc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input arpc_pkg::arpc_out_t out_item
);
    import arpc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_item))
        else $error("stalled result changed");

    a_count_only_flush: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.removed_count != '0 |->
            out_item.status == STATUS_OK && out_item.mac_out == '0)
        else $error("removed count on a non-flush result");

    a_mac_only_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.mac_out != '0 |->
            out_item.status == STATUS_OK && out_item.removed_count == '0)
        else $error("mac returned without a lookup hit");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status != 2'd3)
        else $error("undefined status code");

endmodule

bind arp_cache_with_aging_unit arpc_checker u_checker (.*);

// ===== bench/arp_cache_with_aging_unit_tb.sv =====
// Self-checking bench for the ARP cache with aging: driver, monitor and table predictor.
`timescale 1ns / 1ps

module arp_cache_with_aging_unit_tb;

    import arpc_pkg::*;

    localparam int DEPTH       = DEF_TABLE_DEPTH;
    localparam int KEY_POOL    = 24;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [FUNC_W-1:0] FUNC_LAST = '1;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    arpc_in_t         in_item     = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    arpc_out_t        out_item;
    logic             cfg_wr_en   = 1'b0;
    logic [AGE_W-1:0] cfg_wr_data = MAX_AGE_RESET;

    // table predictor state
    logic               cache_valid [DEPTH];
    logic               cache_perm  [DEPTH];
    logic [IP_W-1:0]    cache_ip    [DEPTH];
    logic [MAC_W-1:0]   cache_mac   [DEPTH];
    logic [STAMP_W-1:0] cache_stamp [DEPTH];
    logic [STAMP_W-1:0] seconds_now;
    logic [AGE_W-1:0]   age_limit;

    arpc_in_t  ops_backlog [$];
    arpc_out_t answers_due [$];

    int send_idle_max = 5;
    int recv_idle_max = 5;
    int send_gap;
    int recv_gap;
    int hold_left;
    bit held_off;
    int items_sent;
    int results_seen;
    int errors;
    int cycles;
    int settings_used;
    int n_hits;
    int n_miss;
    int n_full;
    int n_aged;

    arp_cache_with_aging_unit #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Apply one operation to the predicted table and return the answer it should produce.
    function automatic arpc_out_t cache_apply(input arpc_in_t it);
        arpc_out_t          r;
        int                 hit;
        int                 slot;
        logic [STAMP_W-1:0] age;
        r   = '0;
        hit = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit < 0 && cache_valid[i] && cache_ip[i] == it.ip_addr)
                hit = i;
        end
        case (it.func)
            FUNC_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    r.mac_out = cache_mac[hit];
                    n_hits++;
                end
                else
                begin
                    r.status = STATUS_MISS;
                    n_miss++;
                end
            end
            FUNC_ADD:
            begin
                slot = hit;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (slot < 0 && !cache_valid[i])
                        slot = i;
                end
                if (slot < 0)
                begin
                    r.status = STATUS_FULL;
                    n_full++;
                end
                else
                begin
                    cache_valid[slot] = 1'b1;
                    cache_perm[slot]  = it.is_permanent;
                    cache_ip[slot]    = it.ip_addr;
                    cache_mac[slot]   = it.mac_addr;
                    cache_stamp[slot] = seconds_now;
                end
            end
            FUNC_REMOVE:
            begin
                if (hit >= 0)
                    cache_valid[hit] = 1'b0;
                else
                    r.status = STATUS_MISS;
            end
            FUNC_TICK:
                seconds_now = seconds_now + 1'b1;
            FUNC_FLUSH:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (cache_valid[i] && !cache_perm[i])
                    begin
                        age = seconds_now - cache_stamp[i];
                        if (age > STAMP_W'(age_limit))
                        begin
                            cache_valid[i] = 1'b0;
                            n_aged++;
                            if (r.removed_count != COUNT_MAX)
                                r.removed_count = r.removed_count + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Driver: offer backlog items, hold while stalled, idle a drawn number of cycles after each.
    always @(posedge clk or negedge rst_n)
    begin : sender
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                answers_due.push_back(cache_apply(in_item));
                items_sent++;
            end
            if (in_valid && in_stall)
            begin
                // hold the stalled item
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (ops_backlog.size() > 0)
            begin
                in_item  <= ops_backlog.pop_front();
                in_valid <= 1'b1;
                send_gap = $urandom_range(0, send_idle_max);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each accepted answer against the oldest prediction, stall at random.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        arpc_out_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap  = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (answers_due.size() == 0)
                begin
                    $error("answer with no item pending: %p", out_item);
                    errors++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (out_item.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_item.status);
                        errors++;
                    end
                    if (out_item.mac_out !== want.mac_out)
                    begin
                        $error("mac_out: expected %h, got %h", want.mac_out, out_item.mac_out);
                        errors++;
                    end
                    if (out_item.removed_count !== want.removed_count)
                    begin
                        $error("removed_count: expected %0d, got %0d",
                               want.removed_count, out_item.removed_count);
                        errors++;
                    end
                end
                recv_gap = $urandom_range(0, recv_idle_max);
                // back up the whole pipe once so the input side stalls
                if (!held_off && results_seen == HOLD_AT)
                begin
                    hold_left = HOLD_CYCLES;
                    held_off  = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("arp_cache_with_aging_unit_tb: done, errors");
            $finish;
        end
    end

    task automatic push_op(input logic [FUNC_W-1:0] f, input logic [IP_W-1:0] ip,
                           input logic [MAC_W-1:0] mac, input logic perm);
        arpc_in_t it;
        it.func         = f;
        it.ip_addr      = ip;
        it.mac_addr     = mac;
        it.is_permanent = perm;
        ops_backlog.push_back(it);
    endtask

    // Wait until every pending item has been answered and the block has gone quiet.
    task automatic drain();
        while (ops_backlog.size() != 0 || in_valid || answers_due.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
    endtask

    task automatic set_max_age(input logic [AGE_W-1:0] v);
        drain();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        age_limit = v;
        settings_used++;
    endtask

    // Mostly traffic on a small key set so the table fills, hits and ages; some random noise.
    task automatic random_ops(input int n_items);
        logic [IP_W-1:0]   keys [KEY_POOL];
        arpc_in_t          it;
        int                pick;
        foreach (keys[k])
            keys[k] = $urandom;
        keys[0] = '0;
        keys[1] = '1;
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                it.ip_addr = $urandom;
            else
                it.ip_addr = keys[$urandom_range(0, KEY_POOL - 1)];
            it.mac_addr     = {16'($urandom), 32'($urandom)};
            it.is_permanent = ($urandom_range(0, 3) == 0);
            if (pick < 28)
                it.func = FUNC_LOOKUP;
            else if (pick < 58)
                it.func = FUNC_ADD;
            else if (pick < 73)
                it.func = FUNC_REMOVE;
            else if (pick < 90)
                it.func = FUNC_TICK;
            else if (pick < 97)
                it.func = FUNC_FLUSH;
            else
                it.func = FUNC_W'($urandom_range(FUNC_FLUSH + 1, FUNC_LAST));
            ops_backlog.push_back(it);
        end
    endtask

    initial
    begin
        foreach (cache_valid[i])
        begin
            cache_valid[i] = 1'b0;
            cache_perm[i]  = 1'b0;
        end
        seconds_now   = '0;
        age_limit     = MAX_AGE_RESET;
        settings_used = 1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, both key extremes, overwrite, unused codes, full table
        push_op(FUNC_LOOKUP, '0, '0, 1'b0);
        push_op(FUNC_REMOVE, '1, '0, 1'b0);
        push_op(FUNC_ADD, '0, '0, 1'b0);
        push_op(FUNC_ADD, '1, '1, 1'b1);
        push_op(FUNC_LOOKUP, '1, '0, 1'b0);
        push_op(FUNC_ADD, '0, 48'h5A5A_A5A5_0FF0, 1'b0);
        push_op(FUNC_LOOKUP, '0, '1, 1'b1);
        for (int f = FUNC_FLUSH + 1; f <= FUNC_LAST; f++)
            push_op(FUNC_W'(f), '1, '1, 1'b1);
        push_op(FUNC_TICK, '0, '0, 1'b0);
        push_op(FUNC_FLUSH, '0, '0, 1'b0);
        push_op(FUNC_REMOVE, '0, '0, 1'b0);
        push_op(FUNC_REMOVE, '0, '0, 1'b0);
        for (int k = 0; k < DEPTH - 1; k++)
            push_op(FUNC_ADD, 32'h0A00_0100 + k, {16'($urandom), 32'($urandom)}, 1'b0);
        push_op(FUNC_ADD, 32'hC0A8_0001, '1, 1'b0);
        push_op(FUNC_LOOKUP, 32'h0A00_0105, '0, 1'b0);

        // zero age: one tick later every dynamic entry expires
        set_max_age('0);
        push_op(FUNC_TICK, '0, '0, 1'b0);
        push_op(FUNC_FLUSH, '0, '0, 1'b0);
        push_op(FUNC_LOOKUP, '1, '0, 1'b0);
        push_op(FUNC_LOOKUP, 32'h0A00_0100, '0, 1'b0);
        random_ops(220);

        // nothing ever expires; run back to back with no idling
        set_max_age('1);
        send_idle_max = 0;
        recv_idle_max = 0;
        random_ops(220);

        set_max_age(AGE_W'($urandom_range(1, 8)));
        send_idle_max = 5;
        recv_idle_max = 5;
        random_ops(220);

        // pause the sender mid-phase until every answer is in
        set_max_age(AGE_W'($urandom_range(9, 40)));
        random_ops(110);
        drain();
        random_ops(110);

        set_max_age(MAX_AGE_RESET);
        random_ops(200);

        drain();
        $display("arp_cache_with_aging_unit_tb: %0d items under %0d max_age settings, %0d answers",
                 items_sent, settings_used, results_seen);
        $display("arp_cache_with_aging_unit_tb: %0d hits, %0d misses, %0d full adds, %0d aged out",
                 n_hits, n_miss, n_full, n_aged);
        if (errors == 0)
            $display("arp_cache_with_aging_unit_tb: done, clean");
        else
            $display("arp_cache_with_aging_unit_tb: done, errors");
        $finish;
    end

endmodule

// ===== arp_cache_with_aging_unit.f =====
rtl/arpc_pkg.sv
rtl/arpc_front.sv
rtl/arpc_queue.sv
rtl/arpc_back.sv
rtl/arp_cache_with_aging_unit.sv
rtl/arpc_checker.sv
bench/arp_cache_with_aging_unit_tb.sv
